// File: hdl/srmr_pkg.sv
// Shared types and constants of the stereo repair matrix ramp block.
`default_nettype none

package srmr_pkg;

   // Coefficient lanes, one per matrix entry: 0 = L->L, 1 = R->L, 2 = L->R, 3 = R->R
   localparam int LANES = 4;

   // Control register map
   localparam int REG_IDX_BITS = 3;
   typedef logic [REG_IDX_BITS-1:0] reg_idx_type;

   localparam reg_idx_type REG_ENABLE      = 3'd0;
   localparam reg_idx_type REG_INV_LEFT    = 3'd1;
   localparam reg_idx_type REG_INV_RIGHT   = 3'd2;
   localparam reg_idx_type REG_SWAP        = 3'd3;
   localparam reg_idx_type REG_FOLD        = 3'd4;
   localparam reg_idx_type REG_BALANCE     = 3'd5;
   localparam reg_idx_type REG_STEREO      = 3'd6;
   localparam reg_idx_type REG_RAMP_FRAMES = 3'd7;

   // Balance is a signed percentage, clamped to +/- BAL_LIMIT
   localparam int BAL_BITS  = 8;
   localparam int BAL_LIMIT = 100;
   localparam int BAL_IDX_BITS = 7;

   localparam logic [BAL_BITS-1:0]     BAL_LIMIT_RAW = 8'd100;
   localparam logic [BAL_IDX_BITS-1:0] BAL_LIMIT_IDX = 7'd100;

   typedef enum logic [1:0] {
      CMD_PROCESS = 2'd0,
      CMD_APPLY   = 2'd1,
      CMD_SNAP    = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MULT,
      ST_MERGE,
      ST_LOAD,
      ST_DIV_START,
      ST_DIV,
      ST_DIV_DONE,
      ST_SNAP
   } state_type;

   // Per-cycle commands from the sequencer to every lane
   typedef struct packed {
      logic load_target;
      logic ramp_step;
      logic snap;
      logic div_start;
      logic div_step;
      logic div_done;
      logic mult;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// File: hdl/srmr_req_if.sv
// Request channel: command word with one stereo sample pair.
`default_nettype none

interface srmr_req_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic signed [SAMPLE_BITS-1:0] left_in;
   logic signed [SAMPLE_BITS-1:0] right_in;

   modport source (output valid, cmd, left_in, right_in, input ready);
   modport sink   (input valid, cmd, left_in, right_in, output ready);
endinterface

`default_nettype wire

// File: hdl/srmr_rsp_if.sv
// Response channel: mixed stereo output word with ramp status.
`default_nettype none

interface srmr_rsp_if #(
   parameter int SAMPLE_BITS = 24
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic                          ramp_active;

   modport source (output valid, left_out, right_out, ramp_active, input ready);
   modport sink   (input valid, left_out, right_out, ramp_active, output ready);
endinterface

`default_nettype wire

// File: hdl/srmr_lane.sv
// One coefficient lane: target/current/step state, bit-serial step divider, multiplier.
`default_nettype none

module srmr_lane #(
   parameter int               SAMPLE_BITS     = 24,
   parameter int               COEF_W          = 25,
   parameter int               RAMP_COUNT_BITS = 12,
   parameter logic [COEF_W-1:0] RESET_COEF     = '0
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire srmr_pkg::lane_ctrl_type               ctrl,
   input  wire logic signed [COEF_W-1:0]              target_in,
   input  wire logic [RAMP_COUNT_BITS-1:0]            divisor,
   input  wire logic signed [SAMPLE_BITS-1:0]         sample,
   output logic signed [COEF_W+SAMPLE_BITS-1:0]       product
);

   localparam int PW = COEF_W + SAMPLE_BITS;
   localparam int RB = RAMP_COUNT_BITS;

   logic signed [COEF_W-1:0] target_ff,  target_in_w;
   logic signed [COEF_W-1:0] current_ff, current_in;
   logic signed [COEF_W-1:0] step_ff,    step_in;
   logic        [COEF_W-1:0] mag_ff,     mag_in;
   logic        [RB-1:0]     rem_ff,     rem_in;
   logic                     neg_ff,     neg_in;
   logic signed [PW-1:0]     product_ff, product_in;

   logic signed [COEF_W-1:0] diff;
   logic        [RB:0]       rem_shift;
   logic        [RB:0]       rem_sub;
   logic                     rem_fit;

   always_comb begin
      diff      = target_ff - current_ff;
      rem_shift = {rem_ff, mag_ff[COEF_W-1]};
      rem_sub   = rem_shift - {1'b0, divisor};
      rem_fit   = (rem_shift >= {1'b0, divisor});

      target_in_w = target_ff;
      current_in  = current_ff;
      step_in     = step_ff;
      mag_in      = mag_ff;
      rem_in      = rem_ff;
      neg_in      = neg_ff;
      product_in  = product_ff;

      if (ctrl.load_target) begin
         target_in_w = target_in;
      end
      if (ctrl.ramp_step) begin
         current_in = current_ff + step_ff;
      end
      if (ctrl.snap) begin
         current_in = target_ff;
         step_in    = '0;
      end
      // restoring divide of |target - current| by the ramp length, one bit a cycle
      if (ctrl.div_start) begin
         neg_in = diff[COEF_W-1];
         mag_in = diff[COEF_W-1] ? COEF_W'(-diff) : COEF_W'(diff);
         rem_in = '0;
      end
      if (ctrl.div_step) begin
         rem_in = rem_fit ? rem_sub[RB-1:0] : rem_shift[RB-1:0];
         mag_in = {mag_ff[COEF_W-2:0], rem_fit};
      end
      if (ctrl.div_done) begin
         step_in = neg_ff ? -signed'(mag_ff) : signed'(mag_ff);
      end
      if (ctrl.mult) begin
         product_in = current_ff * sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff  <= RESET_COEF;
         current_ff <= RESET_COEF;
         step_ff    <= '0;
      end else begin
         target_ff  <= target_in_w;
         current_ff <= current_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// File: hdl/srmr_merge.sv
// Merge of lane products: per-output sum, floor shift and saturation; right output zero in mono.
`default_nettype none

module srmr_merge #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 22,
   parameter int PROD_W         = 49
) (
   input  wire logic signed [PROD_W-1:0]      product [srmr_pkg::LANES],
   input  wire logic                          stereo,
   output logic signed [SAMPLE_BITS-1:0]      left_out,
   output logic signed [SAMPLE_BITS-1:0]      right_out
);

   localparam int SUM_W = PROD_W + 1;
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

   logic signed [SUM_W-1:0] sum_l, sum_r;
   logic signed [SUM_W-1:0] shr_l, shr_r;

   function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SUM_W-1:0] v);
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_BITS-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

   always_comb begin
      sum_l = SUM_W'(product[0]) + SUM_W'(product[1]);
      sum_r = SUM_W'(product[2]) + SUM_W'(product[3]);
      shr_l = sum_l >>> COEF_FRAC_BITS;
      shr_r = sum_r >>> COEF_FRAC_BITS;
      left_out  = sat(shr_l);
      right_out = stereo ? sat(shr_r) : '0;
   end

endmodule

`default_nettype wire

// File: hdl/stereo_repair_matrix_ramp_unit.sv
// Top level of the stereo 2x2 mix matrix with linear coefficient ramp.
`default_nettype none

// Stereo repair matrix with gain ramp. Each request word carries a command:
// process mixes one sample pair through the current 2x2 matrix and returns one
// response word (saturated left/right, ramp status); apply builds a new target
// matrix from the control registers and starts a linear ramp of ramp_frames
// frames (zero as one); snap jumps to the target at once; the unused code is dropped.
// Only process produces a response. Coefficients are signed fixed point with
// COEF_FRAC_BITS fraction bits. Four coefficient lanes hold one matrix entry
// each, update and multiply side by side, and a merge stage sums, shifts and
// saturates per output. Sequencer steps per command:
//   process: accept, ramp update, multiply, merge.
//   apply:   accept, target load, divider start, divide in the one-bit-per-
//            cycle step divider of each lane, step write.
//   snap:    accept, snap.  unused code: accept only.
// A new word is taken while a finished response still waits in the output
// register; the merge stage holds only if that register is still full.
// Control registers must be written only while the block is idle.
module stereo_repair_matrix_ramp_unit #(
   parameter int SAMPLE_BITS     = 24,
   parameter int COEF_FRAC_BITS  = 22,
   parameter int RAMP_COUNT_BITS = 12
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   srmr_req_if.sink                                  req_if,
   srmr_rsp_if.source                                rsp_if,
   input  wire logic                                 csr_wr_en,
   input  wire logic [srmr_pkg::REG_IDX_BITS-1:0]    csr_index,
   input  wire logic [RAMP_COUNT_BITS-1:0]           csr_wdata
);

   // coefficient differences span [-2, 2], hence three integer bits
   localparam int CW    = COEF_FRAC_BITS + 3;
   localparam int PW    = CW + SAMPLE_BITS;
   localparam int RB    = RAMP_COUNT_BITS;
   localparam int CNT_W = $clog2(CW);
   localparam logic signed [CW-1:0] ONE = CW'(1) << COEF_FRAC_BITS;

   // ---------------- control registers ----------------
   logic                              enable_ff,   enable_in;
   logic                              inv_l_ff,    inv_l_in;
   logic                              inv_r_ff,    inv_r_in;
   logic                              swap_ff,     swap_in;
   logic                              fold_ff,     fold_in;
   logic signed [srmr_pkg::BAL_BITS-1:0] balance_ff, balance_in;
   logic                              stereo_ff,   stereo_in;
   logic [RB-1:0]                     ramp_frames_ff, ramp_frames_in;

   always_comb begin
      enable_in      = enable_ff;
      inv_l_in       = inv_l_ff;
      inv_r_in       = inv_r_ff;
      swap_in        = swap_ff;
      fold_in        = fold_ff;
      balance_in     = balance_ff;
      stereo_in      = stereo_ff;
      ramp_frames_in = ramp_frames_ff;
      if (csr_wr_en) begin
         case (csr_index)
            srmr_pkg::REG_ENABLE:      enable_in      = csr_wdata[0];
            srmr_pkg::REG_INV_LEFT:    inv_l_in       = csr_wdata[0];
            srmr_pkg::REG_INV_RIGHT:   inv_r_in       = csr_wdata[0];
            srmr_pkg::REG_SWAP:        swap_in        = csr_wdata[0];
            srmr_pkg::REG_FOLD:        fold_in        = csr_wdata[0];
            srmr_pkg::REG_BALANCE:     balance_in     = csr_wdata[srmr_pkg::BAL_BITS-1:0];
            srmr_pkg::REG_STEREO:      stereo_in      = csr_wdata[0];
            srmr_pkg::REG_RAMP_FRAMES: ramp_frames_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= 1'b0;
         inv_l_ff       <= 1'b0;
         inv_r_ff       <= 1'b0;
         swap_ff        <= 1'b0;
         fold_ff        <= 1'b0;
         balance_ff     <= '0;
         stereo_ff      <= 1'b1;
         ramp_frames_ff <= RB'(960);
      end else begin
         enable_ff      <= enable_in;
         inv_l_ff       <= inv_l_in;
         inv_r_ff       <= inv_r_in;
         swap_ff        <= swap_in;
         fold_ff        <= fold_in;
         balance_ff     <= balance_in;
         stereo_ff      <= stereo_in;
         ramp_frames_ff <= ramp_frames_in;
      end
   end

   // ---------------- target matrix build ----------------
   // balance attenuation table: trunc(pct * ONE / 100), pct = 0..100
   logic [CW-1:0] bal_tab [0:srmr_pkg::BAL_LIMIT];

   for (genvar g = 0; g <= srmr_pkg::BAL_LIMIT; g++) begin : gen_bal
      localparam logic [CW-1:0] BAL_ATTN = CW'((64'(g) << COEF_FRAC_BITS) / 64'd100);
      assign bal_tab[g] = BAL_ATTN;
   end

   logic [srmr_pkg::BAL_BITS-1:0]     bal_abs;
   logic [srmr_pkg::BAL_IDX_BITS-1:0] bal_idx;
   logic                              bal_neg, bal_pos;
   logic signed [CW-1:0]              b_mag, lg, rg;
   logic signed [CW-1:0]              m [srmr_pkg::LANES];
   logic signed [CW-1:0]              target [srmr_pkg::LANES];
   logic signed [CW:0]                fold_s, fold_t;

   always_comb begin
      bal_neg = balance_ff[srmr_pkg::BAL_BITS-1];
      bal_pos = !bal_neg && (balance_ff != '0);
      bal_abs = bal_neg ? srmr_pkg::BAL_BITS'(-balance_ff) : balance_ff;
      bal_idx = (bal_abs > srmr_pkg::BAL_LIMIT_RAW) ? srmr_pkg::BAL_LIMIT_IDX
                                                    : bal_abs[srmr_pkg::BAL_IDX_BITS-1:0];
      b_mag   = signed'(bal_tab[bal_idx]);
      lg      = bal_pos ? ONE - b_mag : ONE;
      rg      = bal_neg ? ONE - b_mag : ONE;

      if (swap_ff) begin
         m[0] = '0;
         m[1] = inv_r_ff ? -lg : lg;
         m[2] = inv_l_ff ? -rg : rg;
         m[3] = '0;
      end else begin
         m[0] = inv_l_ff ? -lg : lg;
         m[1] = '0;
         m[2] = '0;
         m[3] = inv_r_ff ? -rg : rg;
      end

      // fold: floor of column averages
      fold_s = ((CW+1)'(m[0]) + (CW+1)'(m[2])) >>> 1;
      fold_t = ((CW+1)'(m[1]) + (CW+1)'(m[3])) >>> 1;

      if (!enable_ff) begin
         target[0] = ONE;  target[1] = '0;
         target[2] = '0;   target[3] = ONE;
      end else if (!stereo_ff) begin
         target[0] = inv_l_ff ? -ONE : ONE;
         target[1] = '0;
         target[2] = '0;
         target[3] = ONE;
      end else if (fold_ff) begin
         target[0] = fold_s[CW-1:0];  target[1] = fold_t[CW-1:0];
         target[2] = fold_s[CW-1:0];  target[3] = fold_t[CW-1:0];
      end else begin
         target[0] = m[0];  target[1] = m[1];
         target[2] = m[2];  target[3] = m[3];
      end
   end

   // ---------------- sequencer ----------------
   srmr_pkg::state_type     state_ff, state_in;
   srmr_pkg::lane_ctrl_type lane_ctrl;
   logic [RB-1:0]           frames_left_ff, frames_left_in;
   logic [CNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic                    req_take;
   logic                    rsp_free;
   logic                    rsp_load;
   logic [RB-1:0]           ramp_len;

   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] left_out_ff, right_out_ff;
   logic                          ramp_active_ff;
   logic signed [SAMPLE_BITS-1:0] mix_left, mix_right;

   assign req_take = req_if.valid && (state_ff == srmr_pkg::ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign ramp_len = (ramp_frames_ff == '0) ? RB'(1) : ramp_frames_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srmr_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_if.cmd)
                  srmr_pkg::CMD_PROCESS: state_in = srmr_pkg::ST_UPDATE;
                  srmr_pkg::CMD_APPLY:   state_in = srmr_pkg::ST_LOAD;
                  srmr_pkg::CMD_SNAP:    state_in = srmr_pkg::ST_SNAP;
                  default:               state_in = srmr_pkg::ST_IDLE;
               endcase
            end
         end
         srmr_pkg::ST_UPDATE:    state_in = srmr_pkg::ST_MULT;
         srmr_pkg::ST_MULT:      state_in = srmr_pkg::ST_MERGE;
         srmr_pkg::ST_MERGE:     state_in = rsp_free ? srmr_pkg::ST_IDLE : srmr_pkg::ST_MERGE;
         srmr_pkg::ST_LOAD:      state_in = srmr_pkg::ST_DIV_START;
         srmr_pkg::ST_DIV_START: state_in = srmr_pkg::ST_DIV;
         srmr_pkg::ST_DIV: begin
            if (div_cnt_ff == CNT_W'(CW - 1)) begin
               state_in = srmr_pkg::ST_DIV_DONE;
            end
         end
         srmr_pkg::ST_DIV_DONE:  state_in = srmr_pkg::ST_IDLE;
         srmr_pkg::ST_SNAP:      state_in = srmr_pkg::ST_IDLE;
         default:                state_in = srmr_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      lane_ctrl      = '0;
      rsp_load       = 1'b0;
      frames_left_in = frames_left_ff;
      div_cnt_in     = div_cnt_ff;
      case (state_ff)
         srmr_pkg::ST_UPDATE: begin
            if (frames_left_ff != '0) begin
               frames_left_in = frames_left_ff - RB'(1);
               // last ramp frame lands exactly on the target
               if (frames_left_ff == RB'(1)) begin
                  lane_ctrl.snap = 1'b1;
               end else begin
                  lane_ctrl.ramp_step = 1'b1;
               end
            end
         end
         srmr_pkg::ST_MULT:  lane_ctrl.mult = 1'b1;
         srmr_pkg::ST_MERGE: rsp_load = rsp_free;
         srmr_pkg::ST_LOAD: begin
            lane_ctrl.load_target = 1'b1;
            frames_left_in        = ramp_len;
         end
         srmr_pkg::ST_DIV_START: begin
            lane_ctrl.div_start = 1'b1;
            div_cnt_in          = '0;
         end
         srmr_pkg::ST_DIV: begin
            lane_ctrl.div_step = 1'b1;
            div_cnt_in         = div_cnt_ff + CNT_W'(1);
         end
         srmr_pkg::ST_DIV_DONE: lane_ctrl.div_done = 1'b1;
         srmr_pkg::ST_SNAP: begin
            lane_ctrl.snap = 1'b1;
            frames_left_in = '0;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= srmr_pkg::ST_IDLE;
         frames_left_ff <= '0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frames_left_ff <= frames_left_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // sample pair is held for the multiply stage
   always_ff @(posedge clock) begin
      if (req_take) begin
         left_ff  <= req_if.left_in;
         right_ff <= req_if.right_in;
      end
      if (rsp_load) begin
         left_out_ff    <= mix_left;
         right_out_ff   <= mix_right;
         ramp_active_ff <= (frames_left_ff != '0);
      end
   end

   // ---------------- lanes and merge ----------------
   logic signed [PW-1:0]          product [srmr_pkg::LANES];
   logic signed [SAMPLE_BITS-1:0] right_src;

   // mono mode never reads the right sample
   assign right_src = stereo_ff ? right_ff : '0;

   for (genvar i = 0; i < srmr_pkg::LANES; i++) begin : gen_lane
      localparam logic [CW-1:0] LANE_RESET = (i == 0 || i == 3) ? ONE : '0;
      srmr_lane #(
         .SAMPLE_BITS     (SAMPLE_BITS),
         .COEF_W          (CW),
         .RAMP_COUNT_BITS (RAMP_COUNT_BITS),
         .RESET_COEF      (LANE_RESET)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .target_in (target[i]),
         .divisor   (frames_left_ff),
         .sample    ((i % 2 == 0) ? left_ff : right_src),
         .product   (product[i])
      );
   end

   srmr_merge #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .PROD_W         (PW)
   ) u_merge (
      .product   (product),
      .stereo    (stereo_ff),
      .left_out  (mix_left),
      .right_out (mix_right)
   );

   assign req_if.ready       = (state_ff == srmr_pkg::ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.left_out    = left_out_ff;
   assign rsp_if.right_out   = right_out_ff;
   assign rsp_if.ramp_active = ramp_active_ff;

`ifndef ASSERT_OFF
   // a processed frame consumes exactly one ramp step
   a_frame_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srmr_pkg::ST_UPDATE && frames_left_ff != '0)
      |=> frames_left_ff == $past(frames_left_ff) - RB'(1))
      else $error("ramp counter did not step by one");

   // an apply always leaves a nonzero divisor for the lanes
   a_apply_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == srmr_pkg::ST_LOAD |=> frames_left_ff != '0)
      else $error("apply loaded a zero ramp length");

   // the divisor stays put for the whole divide
   a_div_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == srmr_pkg::ST_DIV |-> $stable(frames_left_ff))
      else $error("divisor changed during divide");

   // merge waits while the held response is not taken
   a_merge_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == srmr_pkg::ST_MERGE && rsp_valid_ff && !rsp_if.ready)
      |=> state_ff == srmr_pkg::ST_MERGE && rsp_valid_ff)
      else $error("response overwritten while stalled");
`endif

endmodule

`default_nettype wire
